@@ src/stream_prime_sieve_top_defines.svh @@
// Assertion macros for the sieve RTL.
`ifndef STREAM_PRIME_SIEVE_TOP_DEFINES_SVH
`define STREAM_PRIME_SIEVE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/sps_pkg.sv @@
package sps_pkg;

  // Command into the shared remainder unit.
  typedef struct packed {
    logic start;
  } rem_ctl_t;

  // Status back from the remainder unit; zero is meaningful with done.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

endpackage

@@ src/sps_rem.sv @@
// Restoring remainder, one quotient bit per cycle.
// A zero divisor leaves the dividend as remainder, so zero only divides zero.
module sps_rem #(
  parameter int W = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  sps_pkg::rem_ctl_t ctl,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  output sps_pkg::rem_stat_t stat
);
  import sps_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [W:0]    part;
  logic [W:0]    diff;
  logic          fits;

  assign part = {rem, quo[W-1]};
  assign diff = part - {1'b0, dvs};
  assign fits = (part >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= CW'(W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[W-1:0] : part[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.zero = (rem == '0);

endmodule

@@ src/sps_store.sv @@
// Prime store: one write port, one read port with registered data.
module sps_store #(
  parameter int DEPTH = 64,
  parameter int W     = 16,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/stream_prime_sieve_top.sv @@
// Channel   | Signals                         | Direction
// ----------+---------------------------------+----------
// candidate | cand_valid, cand_stall, number, | in
//           | last                            |
// result    | res_valid, res_stall, prime,    | out
//           | overflow                        |
//
// Each candidate is tried against the kept primes in turn until a divisor is
// found or the list ends. Per kept prime the sieve does one store read and
// one launch of the bit-serial remainder unit, then waits for its done.
// Synchronous active-high reset clears the count, so the store reads empty.
// A result stall only blocks the next prime's transfer at the end of its test.
`include "stream_prime_sieve_top_defines.svh"

module stream_prime_sieve_top #(
  parameter int MAX_PRIMES   = 64,
  parameter int NUMBER_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cand_valid,
  output logic                    cand_stall,
  input  logic [NUMBER_WIDTH-1:0] number,
  input  logic                    last,
  output logic                    res_valid,
  input  logic                    res_stall,
  output logic [NUMBER_WIDTH-1:0] prime,
  output logic                    overflow
);
  import sps_pkg::*;

  // Count must reach MAX_PRIMES itself; store address covers the depth.
  localparam int CNT_W = $clog2(MAX_PRIMES + 1);
  localparam int IDX_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PRIMES);

  typedef enum logic [2:0] {
    IDLE,    // waiting for a candidate
    FETCH,   // read kept prime at idx
    LOAD,    // launch remainder against read data
    DIVIDE,  // wait on remainder unit
    FINISH   // emit / store, apply last
  } state_t;

  state_t state;

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        idx_next;
  logic [NUMBER_WIDTH-1:0] num;
  logic                    num_last;
  logic                    is_prime;

  logic                    rd_en;
  logic [NUMBER_WIDTH-1:0] rd_data;
  logic                    wr_en;
  logic                    out_free;
  logic                    fin_go;

  rem_ctl_t                div_ctl;
  rem_stat_t               div_stat;

  assign idx_next   = idx + 1'b1;
  assign cand_stall = (state != IDLE);
  assign rd_en      = (state == FETCH);
  assign out_free   = !res_valid || !res_stall;

  // Leave FINISH once a prime has a free output slot; rejects leave at once.
  assign fin_go = (state == FINISH) && (!is_prime || out_free);
  assign wr_en  = fin_go && is_prime && (count < MAX_CNT);

  assign div_ctl.start = (state == LOAD);

  sps_store #(
    .DEPTH (MAX_PRIMES),
    .W     (NUMBER_WIDTH),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IDX_W-1:0]),
    .wr_data (num),
    .rd_en   (rd_en),
    .rd_addr (idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  sps_rem #(
    .W (NUMBER_WIDTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (num),
    .divisor  (rd_data),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      idx       <= '0;
      is_prime  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // new prime loads the output register; a result transfer frees it
      if (fin_go && is_prime) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (cand_valid) begin
            num      <= number;
            num_last <= last;
            idx      <= '0;
            is_prime <= 1'b1;
            // empty store: first number of a run passes untested
            state    <= (count == '0) ? FINISH : FETCH;
          end
        end
        FETCH: begin
          state <= LOAD;
        end
        LOAD: begin
          state <= DIVIDE;
        end
        DIVIDE: begin
          if (div_stat.done) begin
            if (div_stat.zero) begin
              is_prime <= 1'b0;
              state    <= FINISH;
            end else if (idx_next == count) begin
              state <= FINISH;
            end else begin
              idx   <= idx_next;
              state <= FETCH;
            end
          end
        end
        FINISH: begin
          if (fin_go) begin
            if (is_prime) begin
              prime    <= num;
              overflow <= (count == MAX_CNT);
            end
            if (num_last) begin
              count <= '0;
            end else if (wr_en) begin
              count <= count + 1'b1;
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `SPS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= MAX_CNT, "prime count above capacity")
  `SPS_ASSERT_NOW(a_done_in_divide, clk, rst, div_stat.done, state == DIVIDE, "remainder done outside divide")
  `SPS_ASSERT_NEXT(a_empty_skips, clk, rst, cand_valid && !cand_stall && count == '0, state == FINISH, "empty store must skip testing")
  `SPS_ASSERT_NOW(a_write_room, clk, rst, wr_en, is_prime && count < MAX_CNT, "store write without room")

endmodule
